@@ hdl/mbps_pkg.sv @@
package mbps_pkg;

  // func codes of an input item
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

  // per-cycle control of each cell; step and clear go to all cells
  typedef struct packed {
    logic step;   // a region byte is accepted this cycle
    logic clear;  // that byte closes the region
    logic wr;     // this cell's pattern entry is written this cycle
  } cell_ctl_t;

endpackage

@@ hdl/mbps_cell.sv @@
module mbps_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mbps_pkg::cell_ctl_t ctl,
  input  logic [7:0]         wr_byte,
  input  logic               wr_checked,
  input  logic [7:0]         data_byte,
  input  logic               prev_live,
  output logic               live,
  output logic               match_now
);

  logic [7:0] value_r;
  logic       checked_r;
  logic       live_r;
  logic       live_nxt;

  // prefix ending at this position survives if the shorter one lived a byte ago
  assign match_now = prev_live && (!checked_r || (value_r == data_byte));

  always_comb begin
    live_nxt = live_r;
    if (ctl.step) begin
      live_nxt = ctl.clear ? 1'b0 : match_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      value_r   <= wr_byte;
      checked_r <= wr_checked;
    end
  end

  assign live = live_r;

endmodule

@@ hdl/masked_byte_pattern_search_unit.sv @@
// Timing: the edge that accepts a region byte loads its result into the out_valid register.
// Throughput: one item per cycle while in_stall is low, loads and region bytes alike; the
// shift-and cell chain updates every live prefix in parallel on each accepted region byte.
// in_stall is high only while a result waits in the output register and out_stall is high.
// Reset (rst_n, synchronous, active low) clears live prefixes, offset, report flag,
// output valid and sets pattern_length to 1; pattern entries are not reset.
module masked_byte_pattern_search_unit #(
  parameter int PATTERN_MAX  = 256,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_entry_byte,
  input  logic        in_entry_checked,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_match_offset,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  localparam int CW = ($clog2(PATTERN_MAX + 1) > 9) ? $clog2(PATTERN_MAX + 1) : 9;
  localparam int MW = (OFFSET_WIDTH > CW) ? OFFSET_WIDTH : CW;

  logic [8:0]              pattern_length_r;
  logic [OFFSET_WIDTH-1:0] offset_r, offset_nxt;
  logic                    reported_r, reported_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r;
  logic [31:0]             out_match_offset_r;

  logic in_acc, byte_acc, load_acc;
  logic report, emit, hit;

  logic [CW-1:0] len_ext, len_eff, end_idx;
  logic [MW-1:0] cur_ext, end_ext, start;

  logic [PATTERN_MAX-1:0] live_vec;
  logic [PATTERN_MAX-1:0] match_vec;
  logic [PATTERN_MAX-1:0] end_sel;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign byte_acc = in_acc && (in_func == mbps_pkg::FUNC_BYTE);
  assign load_acc = in_acc && (in_func == mbps_pkg::FUNC_LOAD);

  // clamp length to 1..PATTERN_MAX
  always_comb begin
    len_ext = CW'(pattern_length_r);
    len_eff = len_ext;
    if (len_ext == '0) begin
      len_eff = CW'(1);
    end else if (len_ext > CW'(PATTERN_MAX)) begin
      len_eff = CW'(PATTERN_MAX);
    end
    end_idx = len_eff - CW'(1);
  end

  genvar g;
  generate
    for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
      mbps_pkg::cell_ctl_t ctl;
      logic                prev;

      assign ctl.step  = byte_acc;
      assign ctl.clear = in_last;
      assign ctl.wr    = load_acc && (CW'(in_entry_index) == CW'(g));
      assign end_sel[g] = (end_idx == CW'(g));

      if (g == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_body
        assign prev = live_vec[g-1];
      end

      mbps_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .wr_byte    (in_entry_byte),
        .wr_checked (in_entry_checked),
        .data_byte  (in_data_byte),
        .prev_live  (prev),
        .live       (live_vec[g]),
        .match_now  (match_vec[g])
      );
    end
  endgenerate

  assign hit    = |(match_vec & end_sel);
  assign report = byte_acc && !reported_r && hit;
  assign emit   = report || (byte_acc && in_last && !reported_r);

  always_comb begin
    cur_ext = MW'(offset_r);
    end_ext = MW'(end_idx);
    start   = (cur_ext >= end_ext) ? (cur_ext - end_ext) : '0;
  end

  always_comb begin
    offset_nxt   = offset_r;
    reported_nxt = reported_r;
    if (byte_acc) begin
      if (in_last) begin
        offset_nxt   = '0;
        reported_nxt = 1'b0;
      end else begin
        if (offset_r != '1) begin
          offset_nxt = offset_r + OFFSET_WIDTH'(1);
        end
        reported_nxt = reported_r || report;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= 9'd1;
      offset_r         <= '0;
      reported_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pattern_length_r <= cfg_wr_data;
      end
      offset_r    <= offset_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found_r        <= report;
      out_match_offset_r <= report ? 32'(start) : 32'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_match_offset_r;

  // region end wipes the per-region state
  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && in_last) |=> (offset_r == '0) && !reported_r)
    else $error("region state not cleared after last byte");

  // a match inside a region blocks further reports
  a_report_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (report && !in_last) |=> reported_r)
    else $error("report flag not set after match");

  a_once: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && reported_r) |-> !emit)
    else $error("second result in one region");

  // a new result never overwrites one still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

endmodule
